// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the page version counter controller top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PVC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold later than the antecedent, not in the same cycle.
`define PVC_ASSERT_AFTER3(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##3 (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pvc_pkg.sv =====
`timescale 1ns / 1ps

package pvc_pkg;

    // Fixed field widths and limits
    localparam int ADDR_W         = 24;
    localparam int PAGE_W         = 12;
    localparam int LINE_W         = 6;
    localparam int LINES_PER_PAGE = 64;
    localparam int CTR_W          = 8;
    localparam int WCNT_W         = 7;
    localparam int PTR_W          = 48;
    localparam int MODE_W         = 2;
    localparam int OP_W           = 2;
    localparam int CFG_INDEX_W    = 1;
    localparam int WRITE_LIMIT    = 64;

    // Reciprocal used for page number modulo the page count
    localparam int RECIP_SHIFT    = 24;
    localparam int RECIP_W        = RECIP_SHIFT + 1;

    // Parameter defaults
    localparam int DEF_NUM_PAGES       = 4096;
    localparam int DEF_VAULT_LIMIT     = 127;
    localparam int DEF_ENTRY_SIZE      = 64;
    localparam int DEF_VAULT_STRIDE    = 1;
    localparam int DEF_OVERFLOW_STRIDE = 2;

    typedef enum logic [OP_W-1:0] {
        OP_UPDATE = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_RESET  = 2'd2
    } op_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_ONE_STEP = 2'd0,
        MODE_VAULT    = 2'd1,
        MODE_OVERFLOW = 2'd2
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_VAULT_BASE    = 1'b0,
        REG_OVERFLOW_BASE = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INDEX,
        ST_MODIFY
    } state_t;

    // One page record. seen: one-step line bitmap (counters are 0 or 1 there),
    // frozen at promotion. touched: line counter lives in the line memory.
    typedef struct packed {
        mode_t                     mode;
        logic [WCNT_W-1:0]         wcount;
        logic [PTR_W-1:0]          ptr;
        logic [LINES_PER_PAGE-1:0] seen;
        logic [LINES_PER_PAGE-1:0] touched;
    } page_rec_t;

    localparam int REC_W = $bits(page_rec_t);

endpackage

// ===== rtl/core/page_version_counter_controller_top.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Page version counter controller.
// Command channel: an item (operation, address) transfers at a rising edge with
// start high and busy low. The result (page_mode, entry_address,
// page_entry_address, forced_updates) is driven for exactly one cycle with done
// high; the receiver cannot stall, so every result is taken as it appears.
// Flow: after the transfer edge an item passes the index cycle, the
// read-modify-write cycle and the result register, and then done is high.
// The page record memory and line counter memory each take one read and at most
// one write per item. busy drops during the write-back cycle, so the next item
// can transfer then and its read lands after the previous item's write.
// Config: cfg_write/cfg_index/cfg_data write a base register at the edge. The user
// must write only while no item is in flight; the block itself does not enforce it.
// Reset: all control state clears at once, then a clearing pass writes every
// page record to zero, one per cycle, with busy high.
// The line counter memory is not cleared; a line is read from it only after
// its page's record marks it as written.
module page_version_counter_controller_top #(
    parameter int NUM_PAGES       = pvc_pkg::DEF_NUM_PAGES,
    parameter int VAULT_LIMIT     = pvc_pkg::DEF_VAULT_LIMIT,
    parameter int ENTRY_SIZE      = pvc_pkg::DEF_ENTRY_SIZE,
    parameter int VAULT_STRIDE    = pvc_pkg::DEF_VAULT_STRIDE,
    parameter int OVERFLOW_STRIDE = pvc_pkg::DEF_OVERFLOW_STRIDE
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [pvc_pkg::OP_W-1:0]        operation,
    input  logic [pvc_pkg::ADDR_W-1:0]      address,
    output logic                            done,
    output logic [pvc_pkg::MODE_W-1:0]      page_mode,
    output logic [pvc_pkg::PTR_W-1:0]       entry_address,
    output logic [pvc_pkg::PTR_W-1:0]       page_entry_address,
    output logic [pvc_pkg::WCNT_W-1:0]      forced_updates,
    input  logic                            cfg_write,
    input  logic [pvc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pvc_pkg::PTR_W-1:0]       cfg_data
);

    localparam int PG_W       = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int LINE_DEPTH = NUM_PAGES * pvc_pkg::LINES_PER_PAGE;
    localparam int LAW        = $clog2(LINE_DEPTH);
    localparam int NP_W       = $clog2(NUM_PAGES + 1);
    localparam int QW         = pvc_pkg::PAGE_W + 1;
    localparam int DW         = QW + NP_W;
    localparam int ES_W       = $clog2(ENTRY_SIZE + 1);
    localparam int PE_W       = pvc_pkg::PAGE_W + ES_W;
    localparam int PROD_W     = pvc_pkg::PAGE_W + pvc_pkg::RECIP_W;
    localparam logic [pvc_pkg::RECIP_W-1:0] RECIP =
        pvc_pkg::RECIP_W'((1 << pvc_pkg::RECIP_SHIFT) / NUM_PAGES);
    localparam logic [NP_W-1:0] NP_VAL = NP_W'(NUM_PAGES);
    localparam logic [ES_W-1:0] ES_VAL = ES_W'(ENTRY_SIZE);

    // State machine
    pvc_pkg::state_t state_reg, state_next;
    logic            accept;
    logic            clearing;
    logic            modifying;
    logic            clr_last;
    logic [PG_W-1:0] clr_reg;

    // Item registers
    pvc_pkg::op_t                  op_reg;
    logic [pvc_pkg::LINE_W-1:0]    line_reg;
    logic [pvc_pkg::PAGE_W-1:0]    page_reg;
    logic [QW-1:0]                 q_reg;
    logic [pvc_pkg::PTR_W-1:0]     page_entry_reg;
    logic [PG_W-1:0]               pg_reg;
    logic [pvc_pkg::PAGE_W-1:0]    in_page;
    logic [PROD_W-1:0]             recip_prod;
    logic [PE_W-1:0]               page_entry_prod;

    // Page index (page modulo NUM_PAGES)
    logic [DW-1:0]   qn;
    logic [DW-1:0]   diff;
    logic [DW-1:0]   diff_fix;
    logic [PG_W-1:0] pg_idx;

    // Base and tail registers
    logic [pvc_pkg::PTR_W-1:0] vault_base_reg;
    logic [pvc_pkg::PTR_W-1:0] overflow_base_reg;
    logic [pvc_pkg::PTR_W-1:0] vault_tail_reg, vault_tail_next;
    logic [pvc_pkg::PTR_W-1:0] overflow_tail_reg, overflow_tail_next;
    logic [pvc_pkg::PTR_W-1:0] vault_inc_reg;
    logic [pvc_pkg::PTR_W-1:0] overflow_inc_reg;
    logic [pvc_pkg::PTR_W-1:0] vault_alloc;
    logic [pvc_pkg::PTR_W-1:0] overflow_alloc;

    // Memory ports
    pvc_pkg::page_rec_t          rec_rd;
    pvc_pkg::page_rec_t          rec_next;
    logic [pvc_pkg::REC_W-1:0]   rec_rdata;
    logic [pvc_pkg::REC_W-1:0]   rec_wdata;
    logic [PG_W-1:0]             rec_waddr;
    logic                        rec_we;
    logic                        rec_wr_op;
    logic [pvc_pkg::CTR_W-1:0]   ln_rd;
    logic                        ln_we;
    logic                        ln_wr_op;
    logic [PG_W+pvc_pkg::LINE_W-1:0] ln_raddr_full;
    logic [PG_W+pvc_pkg::LINE_W-1:0] ln_waddr_full;

    // Read-modify-write datapath
    logic [pvc_pkg::CTR_W-1:0]  old_ctr;
    logic [pvc_pkg::CTR_W-1:0]  new_ctr;
    logic [pvc_pkg::WCNT_W-1:0] cnt_inc;
    pvc_pkg::mode_t             res_mode;
    logic [pvc_pkg::PTR_W-1:0]  res_entry;
    logic [pvc_pkg::WCNT_W-1:0] res_forced;

    // Result registers
    logic                        done_reg;
    logic [pvc_pkg::MODE_W-1:0]  page_mode_reg;
    logic [pvc_pkg::PTR_W-1:0]   entry_address_reg;
    logic [pvc_pkg::PTR_W-1:0]   page_entry_address_reg;
    logic [pvc_pkg::WCNT_W-1:0]  forced_updates_reg;

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pvc_pkg::ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = pvc_pkg::ST_IDLE;
                end
            end
            pvc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = pvc_pkg::ST_INDEX;
                end
            end
            pvc_pkg::ST_INDEX:
            begin
                state_next = pvc_pkg::ST_MODIFY;
            end
            pvc_pkg::ST_MODIFY:
            begin
                state_next = start ? pvc_pkg::ST_INDEX : pvc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pvc_pkg::ST_IDLE;
            end
        endcase
    end

    // State decode
    always_comb
    begin
        clearing  = 1'b0;
        modifying = 1'b0;
        busy      = 1'b0;
        case (state_reg)
            pvc_pkg::ST_CLEAR:
            begin
                clearing = 1'b1;
                busy     = 1'b1;
            end
            pvc_pkg::ST_INDEX:
            begin
                busy = 1'b1;
            end
            pvc_pkg::ST_MODIFY:
            begin
                modifying = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    assign accept   = start && !busy;
    assign clr_last = (clr_reg == PG_W'(NUM_PAGES - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pvc_pkg::ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_reg <= clr_reg + PG_W'(1);
            end
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vault_base_reg    <= '0;
            overflow_base_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (pvc_pkg::cfg_reg_t'(cfg_index))
                pvc_pkg::REG_VAULT_BASE:    vault_base_reg    <= cfg_data;
                pvc_pkg::REG_OVERFLOW_BASE: overflow_base_reg <= cfg_data;
                default:                    vault_base_reg    <= vault_base_reg;
            endcase
        end
    end

    // Capture on transfer: operation, line, page, quotient estimate and one-step entry address
    assign in_page         = address[pvc_pkg::ADDR_W-1 -: pvc_pkg::PAGE_W];
    assign recip_prod      = PROD_W'(in_page) * PROD_W'(RECIP);
    assign page_entry_prod = PE_W'(in_page) * PE_W'(ES_VAL);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg         <= pvc_pkg::op_t'(operation);
            line_reg       <= address[pvc_pkg::LINE_W +: pvc_pkg::LINE_W];
            page_reg       <= in_page;
            q_reg          <= recip_prod[pvc_pkg::RECIP_SHIFT +: QW];
            page_entry_reg <= pvc_pkg::PTR_W'(page_entry_prod);
        end
    end

    // Index cycle: remainder with one correction step
    assign qn       = DW'(q_reg) * DW'(NP_VAL);
    assign diff     = DW'(page_reg) - qn;
    assign diff_fix = (diff >= DW'(NUM_PAGES)) ? (diff - DW'(NUM_PAGES)) : diff;
    assign pg_idx   = diff_fix[PG_W-1:0];
    assign ln_raddr_full = {pg_idx, line_reg};

    always_ff @(posedge clk)
    begin
        if (state_reg == pvc_pkg::ST_INDEX)
        begin
            pg_reg           <= pg_idx;
            vault_inc_reg    <= vault_tail_reg + pvc_pkg::PTR_W'(VAULT_STRIDE);
            overflow_inc_reg <= overflow_tail_reg + pvc_pkg::PTR_W'(OVERFLOW_STRIDE);
        end
    end

    // Candidate allocations
    assign vault_alloc    = vault_base_reg + vault_inc_reg;
    assign overflow_alloc = overflow_base_reg + overflow_inc_reg;

    // Read-modify-write of the page record and line counter
    assign rec_rd = pvc_pkg::page_rec_t'(rec_rdata);

    always_comb
    begin
        rec_next           = rec_rd;
        rec_wr_op          = 1'b0;
        ln_wr_op           = 1'b0;
        vault_tail_next    = vault_tail_reg;
        overflow_tail_next = overflow_tail_reg;
        res_mode           = rec_rd.mode;
        res_entry          = rec_rd.ptr;
        res_forced         = '0;
        old_ctr            = rec_rd.touched[line_reg] ? ln_rd
                                                      : pvc_pkg::CTR_W'(rec_rd.seen[line_reg]);
        new_ctr            = old_ctr + pvc_pkg::CTR_W'(1);
        cnt_inc            = (rec_rd.wcount >= pvc_pkg::WCNT_W'(pvc_pkg::WRITE_LIMIT))
                           ? pvc_pkg::WCNT_W'(pvc_pkg::WRITE_LIMIT)
                           : rec_rd.wcount + pvc_pkg::WCNT_W'(1);
        case (op_reg)
            pvc_pkg::OP_UPDATE:
            begin
                rec_wr_op = 1'b1;
                // promotion
                case (rec_rd.mode)
                    pvc_pkg::MODE_ONE_STEP:
                    begin
                        if (new_ctr > pvc_pkg::CTR_W'(1))
                        begin
                            rec_next.mode   = pvc_pkg::MODE_VAULT;
                            rec_next.ptr    = vault_alloc;
                            vault_tail_next = vault_inc_reg;
                        end
                    end
                    pvc_pkg::MODE_VAULT:
                    begin
                        if (new_ctr >= pvc_pkg::CTR_W'(VAULT_LIMIT))
                        begin
                            rec_next.mode      = pvc_pkg::MODE_OVERFLOW;
                            rec_next.ptr       = overflow_alloc;
                            overflow_tail_next = overflow_inc_reg;
                        end
                    end
                    default:
                    begin
                        rec_next.mode = rec_rd.mode;
                    end
                endcase
                // counter and write count
                if (rec_next.mode == pvc_pkg::MODE_ONE_STEP)
                begin
                    rec_next.seen[line_reg] = 1'b1;
                    if (cnt_inc == pvc_pkg::WCNT_W'(pvc_pkg::WRITE_LIMIT))
                    begin
                        rec_next.wcount = '0;
                        rec_next.seen   = '0;
                    end
                    else
                    begin
                        rec_next.wcount = cnt_inc;
                    end
                end
                else
                begin
                    rec_next.touched[line_reg] = 1'b1;
                    rec_next.wcount            = cnt_inc;
                    ln_wr_op                   = 1'b1;
                end
                res_mode  = rec_next.mode;
                res_entry = rec_next.ptr;
            end
            pvc_pkg::OP_RESET:
            begin
                if (rec_rd.mode != pvc_pkg::MODE_ONE_STEP)
                begin
                    res_forced = pvc_pkg::WCNT_W'(pvc_pkg::WRITE_LIMIT);
                end
                else
                begin
                    rec_wr_op = 1'b1;
                    rec_next  = '0;
                    res_entry = '0;
                    if (rec_rd.wcount == '0 ||
                        rec_rd.wcount >= pvc_pkg::WCNT_W'(pvc_pkg::WRITE_LIMIT))
                    begin
                        res_forced = '0;
                    end
                    else
                    begin
                        res_forced = pvc_pkg::WCNT_W'(pvc_pkg::WRITE_LIMIT) - rec_rd.wcount;
                    end
                end
            end
            default:
            begin
                // lookup, and the unused code
                res_entry = (rec_rd.mode == pvc_pkg::MODE_ONE_STEP) ? page_entry_reg
                                                                    : rec_rd.ptr;
            end
        endcase
    end

    // Write port selection: clearing pass or write-back
    assign rec_we        = clearing || (modifying && rec_wr_op);
    assign rec_waddr     = clearing ? clr_reg : pg_reg;
    assign rec_wdata     = clearing ? '0 : rec_next;
    assign ln_we         = modifying && ln_wr_op;
    assign ln_waddr_full = {pg_reg, line_reg};

    pvc_ram #(
        .WIDTH (pvc_pkg::REC_W),
        .DEPTH (NUM_PAGES),
        .AW    (PG_W)
    ) u_rec_ram (
        .clk   (clk),
        .we    (rec_we),
        .waddr (rec_waddr),
        .wdata (rec_wdata),
        .raddr (pg_idx),
        .rdata (rec_rdata)
    );

    pvc_ram #(
        .WIDTH (pvc_pkg::CTR_W),
        .DEPTH (LINE_DEPTH),
        .AW    (LAW)
    ) u_line_ram (
        .clk   (clk),
        .we    (ln_we),
        .waddr (ln_waddr_full[LAW-1:0]),
        .wdata (new_ctr),
        .raddr (ln_raddr_full[LAW-1:0]),
        .rdata (ln_rd)
    );

    // Region tails
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vault_tail_reg    <= '0;
            overflow_tail_reg <= '0;
        end
        else if (modifying)
        begin
            vault_tail_reg    <= vault_tail_next;
            overflow_tail_reg <= overflow_tail_next;
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= modifying;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (modifying)
        begin
            page_mode_reg          <= res_mode;
            entry_address_reg      <= res_entry;
            page_entry_address_reg <= page_entry_reg;
            forced_updates_reg     <= res_forced;
        end
    end

    assign done               = done_reg;
    assign page_mode          = page_mode_reg;
    assign entry_address      = entry_address_reg;
    assign page_entry_address = page_entry_address_reg;
    assign forced_updates     = forced_updates_reg;

    // Checks
    `PVC_ASSERT_AFTER3(a_result_follows_transfer, clk, rst_n, start && !busy, done, "result missing three cycles after transfer")
    `PVC_ASSERT_NOW(a_mode_never_demoted, clk, rst_n, modifying && op_reg == pvc_pkg::OP_UPDATE, rec_next.mode >= rec_rd.mode, "update lowered the page mode")
    `PVC_ASSERT_NOW(a_forced_in_range, clk, rst_n, done, forced_updates <= pvc_pkg::WCNT_W'(pvc_pkg::WRITE_LIMIT), "forced update count above line count")

endmodule

// ===== rtl/core/pvc_ram.sv =====
`timescale 1ns / 1ps

// Single-port-write, single-port-read RAM with registered read data
module pvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
